// ===== rtl/core/ellipse_row_span_core_defines.svh =====
// Assertion macros for the ellipse row span core.
`ifndef ELLIPSE_ROW_SPAN_CORE_DEFINES_SVH
`define ELLIPSE_ROW_SPAN_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ERS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ERS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ers_pkg.sv =====
// Shared types, constants and helpers for the ellipse row span core.
package ers_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [62:0] MAG_LIMIT = 63'h4000_0000_0000_0000;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_Q_XX     = 3'd2;
  localparam logic [2:0] REG_Q_YY     = 3'd3;
  localparam logic [2:0] REG_Q_XY     = 3'd4;

  typedef struct packed {
    logic signed [47:0] p;
    logic signed [47:0] r;
    logic signed [47:0] t;
  } ers_terms_t;

  typedef struct packed {
    logic               vld;
    logic               neg;
    logic signed [15:0] row;
    logic signed [63:0] x;
  } ers_tag_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_P,
    ST_SET_P,
    ST_MUL_R,
    ST_SUM_R,
    ST_LOAD_T,
    ST_DIV_T,
    ST_SET_T
  } ers_state_t;

  typedef struct packed {
    logic busy;
    logic zero_set;
    logic load_p;
    logic step;
    logic set_p;
    logic mul;
    logic sum_r;
    logic load_t;
    logic set_t;
  } ers_dctl_t;

  // product magnitude clamp at 2^62
  function automatic logic [62:0] sat_mag(input logic [127:0] v);
    sat_mag = (v > {65'd0, MAG_LIMIT}) ? MAG_LIMIT : v[62:0];
  endfunction

endpackage

// ===== rtl/core/ers_derive.sv =====
// Derivation of slope, width and curvature terms after configuration writes.
module ers_derive import ers_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic        [39:0] q_xx,
  input  logic        [39:0] q_yy,
  input  logic signed [39:0] q_xy,
  output ers_terms_t         terms,
  output logic               busy
);

  localparam int NUM_W = 48 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] QCAP = NUM_W'(64'h0000_8000_0000_0000);

  ers_state_t        state, state_next;
  ers_dctl_t         ctl;
  logic [NUM_W-1:0]  num, quo;
  logic [39:0]       rem;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [43:0]       pp00, pp01, pp10, pp11;
  logic              prod_neg;

  logic [40:0]        rem_sh;
  logic               ge;
  logic [39:0]        rem_next;
  logic [47:0]        capped;
  logic signed [47:0] div_res;
  logic [39:0]        qxy_mag;
  logic [47:0]        p_mag, r_mag;
  logic [127:0]       wsum;
  logic [62:0]        m;
  logic signed [63:0] sp, diff;
  logic signed [47:0] r_new;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   state_next = ST_IDLE;
      ST_START:  state_next = (q_yy == 40'd0) ? ST_IDLE : ST_DIV_P;
      ST_DIV_P:  state_next = (cnt == CNT_W'(1)) ? ST_SET_P : ST_DIV_P;
      ST_SET_P:  state_next = ST_MUL_R;
      ST_MUL_R:  state_next = ST_SUM_R;
      ST_SUM_R:  state_next = ST_LOAD_T;
      ST_LOAD_T: state_next = ST_DIV_T;
      ST_DIV_T:  state_next = (cnt == CNT_W'(1)) ? ST_SET_T : ST_DIV_T;
      ST_SET_T:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
    if (cfg_wr) state_next = ST_START;
  end

  // control outputs
  always_comb begin
    ctl = '0;
    ctl.busy = (state != ST_IDLE);
    case (state)
      ST_START: begin
        ctl.zero_set = (q_yy == 40'd0);
        ctl.load_p   = (q_yy != 40'd0);
      end
      ST_DIV_P:  ctl.step   = 1'b1;
      ST_SET_P:  ctl.set_p  = 1'b1;
      ST_MUL_R:  ctl.mul    = 1'b1;
      ST_SUM_R:  ctl.sum_r  = 1'b1;
      ST_LOAD_T: ctl.load_t = 1'b1;
      ST_DIV_T:  ctl.step   = 1'b1;
      ST_SET_T:  ctl.set_t  = 1'b1;
      default: ;
    endcase
  end

  assign busy = ctl.busy;

  // restoring divider step and result shaping
  always_comb begin
    rem_sh   = {rem, num[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, q_yy});
    rem_next = ge ? 40'(rem_sh - {1'b0, q_yy}) : rem_sh[39:0];
    capped   = (quo > QCAP) ? 48'h8000_0000_0000 : quo[47:0];
    if (neg)
      div_res = signed'(48'(~capped + 48'd1));
    else
      div_res = capped[47] ? 48'sh7FFF_FFFF_FFFF : signed'(capped);
    qxy_mag = q_xy[39] ? 40'(-q_xy) : 40'(q_xy);
    p_mag   = terms.p[47] ? 48'(-terms.p) : 48'(terms.p);
    r_mag   = terms.r[47] ? 48'(-terms.r) : 48'(terms.r);
    wsum    = (128'(pp11) << 44) + (128'(pp10) << 20) + (128'(pp01) << 24) + 128'(pp00);
    m       = sat_mag(wsum >> FRAC_BITS);
    sp      = prod_neg ? -signed'({1'b0, m}) : signed'({1'b0, m});
    diff    = signed'(64'(q_xx)) - sp;
    if (diff > 64'sh0000_7FFF_FFFF_FFFF)
      r_new = 48'sh7FFF_FFFF_FFFF;
    else if (diff < -64'sh0000_8000_0000_0000)
      r_new = 48'sh8000_0000_0000;
    else
      r_new = diff[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      terms <= '0;
    end else begin
      state <= state_next;
      if (ctl.zero_set) begin
        terms.p <= '0;
        terms.t <= '0;
        terms.r <= signed'({8'd0, q_xx});
      end
      if (ctl.set_p) terms.p <= div_res;
      if (ctl.set_t) terms.t <= div_res;
      if (ctl.sum_r) terms.r <= r_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_p) begin
      num <= NUM_W'(qxy_mag) << FRAC_BITS;
      neg <= q_xy[39];
      rem <= '0;
      quo <= '0;
      cnt <= CNT_W'(NUM_W);
    end else if (ctl.load_t) begin
      num <= NUM_W'(r_mag) << FRAC_BITS;
      neg <= terms.r[47];
      rem <= '0;
      quo <= '0;
      cnt <= CNT_W'(NUM_W);
    end else if (ctl.step) begin
      num <= num << 1;
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (ctl.mul) begin
      pp00     <= 44'(qxy_mag[19:0]  * p_mag[23:0]);
      pp01     <= 44'(qxy_mag[19:0]  * p_mag[47:24]);
      pp10     <= 44'(qxy_mag[39:20] * p_mag[23:0]);
      pp11     <= 44'(qxy_mag[39:20] * p_mag[47:24]);
      prod_neg <= q_xy[39] ^ terms.p[47];
    end
  end

endmodule

// ===== rtl/core/ers_row_front.sv =====
// Row front end: center offset, slope and curvature products, radicand.
module ers_row_front import ers_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [15:0] row_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  ers_terms_t         terms,
  output ers_tag_t           tag,
  output logic signed [63:0] s
);

  localparam int YC_W = ((16 + FRAC_BITS) > 32 ? (16 + FRAC_BITS) : 32) + 1;

  // stage 1
  logic                   v1;
  logic signed [15:0]     row1;
  logic signed [YC_W-1:0] yc1;
  // stage 2
  logic                   v2, xneg2;
  logic signed [15:0]     row2;
  logic [2*YC_W-1:0]      yy2;
  logic [YC_W+23:0]       pxl2, pxh2;
  // stage 3
  logic                   v3;
  logic signed [15:0]     row3;
  logic [62:0]            sq3;
  logic signed [63:0]     x3;
  // stage 4
  logic                   v4, tneg4;
  logic signed [15:0]     row4;
  logic signed [63:0]     x4;
  logic [63:0]            pp00, pp01, pp10, pp11;

  logic [YC_W-1:0]    ym;
  logic [47:0]        pm, tm;
  logic [62:0]        pxm, vm;
  logic signed [63:0] pxs, vs, s_new;

  always_comb begin
    ym    = yc1[YC_W-1] ? YC_W'(-yc1) : YC_W'(yc1);
    pm    = terms.p[47] ? 48'(-terms.p) : 48'(terms.p);
    tm    = terms.t[47] ? 48'(-terms.t) : 48'(terms.t);
    pxm   = sat_mag(((128'(pxh2) << 24) + 128'(pxl2)) >> FRAC_BITS);
    pxs   = xneg2 ? -signed'({1'b0, pxm}) : signed'({1'b0, pxm});
    vm    = sat_mag(((128'(pp11) << 64) + (128'(pp01) << 32) + (128'(pp10) << 32)
                     + 128'(pp00)) >> FRAC_BITS);
    vs    = tneg4 ? -signed'({1'b0, vm}) : signed'({1'b0, vm});
    s_new = 64'(terms.r) - vs;
  end

  // tag: valid bit reset, other fields follow it
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      tag.vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      tag.vld <= v4;
      tag.row <= row4;
      tag.x   <= x4;
      tag.neg <= s_new[63];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row1  <= row_y;
      yc1   <= (YC_W'(row_y) <<< FRAC_BITS) - YC_W'(center_y);
      row2  <= row1;
      yy2   <= (2*YC_W)'(ym * ym);
      pxl2  <= (YC_W+24)'(pm[23:0] * ym);
      pxh2  <= (YC_W+24)'(pm[47:24] * ym);
      xneg2 <= terms.p[47] ^ yc1[YC_W-1];
      row3  <= row2;
      sq3   <= sat_mag(128'(yy2) >> FRAC_BITS);
      x3    <= pxs + 64'(center_x);
      row4  <= row3;
      x4    <= x3;
      pp00  <= 64'(tm[31:0]  * sq3[31:0]);
      pp01  <= 64'(tm[31:0]  * sq3[62:32]);
      pp10  <= 64'(tm[47:32] * sq3[31:0]);
      pp11  <= 64'(tm[47:32] * sq3[62:32]);
      tneg4 <= terms.t[47];
      s     <= s_new;
    end
  end

endmodule

// ===== rtl/core/ers_sqrt_cell.sv =====
// One cell of the square-root chain: one result bit per cell.
module ers_sqrt_cell import ers_pkg::*; #(
  parameter int SQ_N = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ers_tag_t            tag_in,
  input  logic [2*SQ_N-1:0]   rad_in,
  input  logic [SQ_N+1:0]     rem_in,
  input  logic [SQ_N-1:0]     root_in,
  output ers_tag_t            tag_out,
  output logic [2*SQ_N-1:0]   rad_out,
  output logic [SQ_N+1:0]     rem_out,
  output logic [SQ_N-1:0]     root_out
);

  logic [SQ_N+3:0] acc, trial, diff;
  logic            ge;

  always_comb begin
    acc   = {rem_in, rad_in[2*SQ_N-1 -: 2]};
    trial = (SQ_N+4)'({root_in, 2'b01});
    ge    = (acc >= trial);
    diff  = acc - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in << 2;
      rem_out  <= ge ? diff[SQ_N+1:0] : acc[SQ_N+1:0];
      root_out <= {root_in[SQ_N-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/ellipse_row_span_core.sv =====
// Top level of the ellipse row span core: register port, row pipeline, sqrt chain.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  row in   | row_valid / row_stall     | row_y
//  span out | span_valid / span_stall   | row_out, has_span, span_x_min/max
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata (64-bit bus)
//
// One row per cycle sustained while nothing stalls; the square-root cell chain
// computes one result bit per cell.
// After any register write the derive unit recomputes the terms (its one-bit-
// per-cycle divider runs twice unless q_yy is zero); rows stall meanwhile.
// Reset (rst, synchronous) clears registers, derived terms and all valid bits.
// A stall on a valid span freezes the whole pipeline; row_stall follows it.
`include "ellipse_row_span_core_defines.svh"
module ellipse_row_span_core import ers_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [5:0]                   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready,
  // row input
  input  logic                         row_valid,
  output logic                         row_stall,
  input  logic signed [15:0]           row_y,
  // span output
  output logic                         span_valid,
  input  logic                         span_stall,
  output logic signed [15:0]           row_out,
  output logic                         has_span,
  output logic signed [COORD_BITS-1:0] span_x_min,
  output logic signed [COORD_BITS-1:0] span_x_max
);

  // sqrt cells: radicand s << FRAC_BITS is below 2^(63+FRAC_BITS)
  localparam int SQ_N = (63 + FRAC_BITS + 1) / 2;
  localparam logic signed [63:0] C_MAX = 64'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [63:0] C_MIN = -64'(64'sd1 <<< (COORD_BITS - 1));
  localparam logic signed [63:0] F_MASK = 64'((64'sd1 <<< FRAC_BITS) - 64'sd1);

  // configuration registers
  logic signed [31:0] center_x, center_y;
  logic        [39:0] q_xx, q_yy;
  logic signed [39:0] q_xy;

  logic [2:0]  reg_idx;
  logic        cfg_wr;
  logic        dbusy;
  logic        en;
  ers_terms_t  terms;

  // front end outputs
  ers_tag_t           f_tag;
  logic signed [63:0] f_s;

  // sqrt chain taps
  ers_tag_t          c_tag  [SQ_N+1];
  logic [2*SQ_N-1:0] c_rad  [SQ_N+1];
  logic [SQ_N+1:0]   c_rem  [SQ_N+1];
  logic [SQ_N-1:0]   c_root [SQ_N+1];

  // end stage
  ers_tag_t           e_tag;
  logic signed [63:0] e_xmin, e_xmax;
  logic signed [63:0] d_s, lo, hi;
  logic               empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite & (reg_idx <= REG_Q_XY);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      q_xx     <= '0;
      q_yy     <= '0;
      q_xy     <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CENTER_X: center_x <= pwdata[31:0];
        REG_CENTER_Y: center_y <= pwdata[31:0];
        REG_Q_XX:     q_xx     <= pwdata[39:0];
        REG_Q_YY:     q_yy     <= pwdata[39:0];
        REG_Q_XY:     q_xy     <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = 64'(center_x);
      REG_CENTER_Y: prdata = 64'(center_y);
      REG_Q_XX:     prdata = 64'(q_xx);
      REG_Q_YY:     prdata = 64'(q_yy);
      REG_Q_XY:     prdata = 64'(q_xy);
      default:      prdata = '0;
    endcase
  end

  // derived terms, recomputed after each write
  ers_derive #(.FRAC_BITS(FRAC_BITS)) u_derive (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .q_xx   (q_xx),
    .q_yy   (q_yy),
    .q_xy   (q_xy),
    .terms  (terms),
    .busy   (dbusy)
  );

  // whole pipeline moves unless a finished span is held
  assign en        = !(span_valid && span_stall);
  assign row_stall = dbusy | !en;

  ers_row_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (row_valid & ~row_stall),
    .row_y    (row_y),
    .center_x (center_x),
    .center_y (center_y),
    .terms    (terms),
    .tag      (f_tag),
    .s        (f_s)
  );

  // chain head: radicand is s << FRAC_BITS (only meaningful for s >= 0)
  assign c_tag[0]  = f_tag;
  assign c_rad[0]  = (2*SQ_N)'(f_s[62:0]) << FRAC_BITS;
  assign c_rem[0]  = '0;
  assign c_root[0] = '0;

  for (genvar i = 0; i < SQ_N; i++) begin : g_cell
    ers_sqrt_cell #(.SQ_N(SQ_N)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .tag_in   (c_tag[i]),
      .rad_in   (c_rad[i]),
      .rem_in   (c_rem[i]),
      .root_in  (c_root[i]),
      .tag_out  (c_tag[i+1]),
      .rad_out  (c_rad[i+1]),
      .rem_out  (c_rem[i+1]),
      .root_out (c_root[i+1])
    );
  end

  // span ends: ceil of left boundary, floor of right boundary
  always_comb begin
    d_s   = signed'(64'(c_root[SQ_N]));
    lo    = c_tag[SQ_N].x - d_s;
    hi    = c_tag[SQ_N].x + d_s;
    empty = e_tag.neg || (e_xmax < e_xmin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_tag.vld  <= 1'b0;
      span_valid <= 1'b0;
    end else if (en) begin
      e_tag      <= c_tag[SQ_N];
      span_valid <= e_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_xmin  <= (lo + F_MASK) >>> FRAC_BITS;
      e_xmax  <= hi >>> FRAC_BITS;
      row_out <= e_tag.row;
      has_span <= !empty;
      if (empty) begin
        span_x_min <= '0;
        span_x_max <= '0;
      end else begin
        span_x_min <= (e_xmin > C_MAX) ? C_MAX[COORD_BITS-1:0] :
                      (e_xmin < C_MIN) ? C_MIN[COORD_BITS-1:0] : e_xmin[COORD_BITS-1:0];
        span_x_max <= (e_xmax > C_MAX) ? C_MAX[COORD_BITS-1:0] :
                      (e_xmax < C_MIN) ? C_MIN[COORD_BITS-1:0] : e_xmax[COORD_BITS-1:0];
      end
    end
  end

  // checks
  `ERS_ASSERT_NOW(a_busy_blocks_rows, dbusy, row_stall, "row taken while terms are derived")
  `ERS_ASSERT_NEXT(a_write_starts_derive, cfg_wr, dbusy, "register write did not start derive")
  `ERS_ASSERT_NOW(a_empty_zero_ends, span_valid && !has_span, (span_x_min == '0) && (span_x_max == '0), "empty span with nonzero ends")
  `ERS_ASSERT_NOW(a_span_ordered, span_valid && has_span, span_x_min <= span_x_max, "span ends out of order")

endmodule
